// ===== design/mbsp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the MIDI byte stream parser.
// No dependencies; used by every module under design/.
package mbsp_pkg;

  // stored system exclusive bytes
  localparam int SYSEX_DEPTH = 32;
  localparam int SX_AW       = (SYSEX_DEPTH > 1) ? $clog2(SYSEX_DEPTH) : 1;
  localparam int LEN_W       = 6;

  // message type codes
  localparam logic [3:0] MT_NOTEOFF     = 4'd0;
  localparam logic [3:0] MT_NOTEON      = 4'd1;
  localparam logic [3:0] MT_POLYPRESS   = 4'd2;
  localparam logic [3:0] MT_CC          = 4'd3;
  localparam logic [3:0] MT_PROGRAM     = 4'd4;
  localparam logic [3:0] MT_CHANPRESS   = 4'd5;
  localparam logic [3:0] MT_BEND        = 4'd6;
  localparam logic [3:0] MT_SYSCOMMON   = 4'd7;
  localparam logic [3:0] MT_REALTIME    = 4'd8;
  localparam logic [3:0] MT_CHANMODE    = 4'd9;
  localparam logic [3:0] MT_NONE        = 4'd10;

  // system common subtypes: sysex start, and two that take one data byte
  localparam logic [2:0] SC_SYSEX       = 3'd0;
  localparam logic [2:0] SC_QFRAME      = 3'd1;
  localparam logic [2:0] SC_SONGSEL     = 3'd3;
  // song position, two data bytes
  localparam logic [2:0] SC_SONGPOS     = 3'd2;

  localparam logic [7:0] BYTE_EOX       = 8'hF7;
  localparam logic [4:0] RT_PREFIX      = 5'b11111;
  localparam logic [6:0] MODE_BASE      = 7'd120;
  localparam logic [6:0] CC_LAST        = 7'd119;

  typedef enum logic [1:0] {
    PH_EMPTY,
    PH_STATUS,
    PH_FIRST,
    PH_SYSEX
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_READ,
    BK_LOAD
  } back_state_t;

  // one completed message, as handed from front to back
  typedef struct packed {
    logic [3:0]       msg_type;
    logic [3:0]       channel;
    logic [6:0]       first_data;
    logic [6:0]       second_data;
    logic [2:0]       common_subtype;
    logic [2:0]       realtime_subtype;
    logic [2:0]       mode_subtype;
    logic [LEN_W-1:0] sysex_count;
  } event_t;

  // sysex store write port
  typedef struct packed {
    logic             en;
    logic [SX_AW-1:0] addr;
    logic [7:0]       data;
  } sx_wr_t;

endpackage

// ===== design/mbsp_front.sv =====
`timescale 1ns / 1ps
// Front end: byte acceptance, parser phase, running status, message build.
// Depends on mbsp_pkg; feeds mbsp_queue and the sysex store in mbsp_back.
module mbsp_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_byte,
  input  logic                q_full,
  output logic                push,
  output mbsp_pkg::event_t    push_event,
  output mbsp_pkg::sx_wr_t    sx_wr,
  input  logic                sx_done
);

  mbsp_pkg::phase_t                 phase, phase_next;
  logic [3:0]                       running_type, running_type_next;
  logic [3:0]                       cur_type, cur_type_next;
  logic [3:0]                       cur_channel, cur_channel_next;
  logic [6:0]                       cur_first, cur_first_next;
  logic [6:0]                       cur_second, cur_second_next;
  logic [2:0]                       cur_common, cur_common_next;
  logic [2:0]                       cur_realtime, cur_realtime_next;
  logic [2:0]                       cur_mode, cur_mode_next;
  logic [mbsp_pkg::LEN_W-1:0]       sysex_length, sysex_length_next;
  logic                             sx_wait;
  logic                             emit;
  logic                             accept;
  logic                             is_status;
  mbsp_pkg::event_t                 ev;
  mbsp_pkg::sx_wr_t                 wr;
  logic [6:0]                       mode_diff;

  // hold input while a sysex run replays from the store or the queue is full
  assign in_ready  = !sx_wait && !q_full;
  assign accept    = in_valid && in_ready;
  assign is_status = in_byte[7];
  assign push      = accept && emit;
  assign push_event = ev;
  assign sx_wr     = '{en: accept && wr.en, addr: wr.addr, data: wr.data};

  always_comb begin
    phase_next        = phase;
    running_type_next = running_type;
    cur_type_next     = cur_type;
    cur_channel_next  = cur_channel;
    cur_first_next    = cur_first;
    cur_second_next   = cur_second;
    cur_common_next   = cur_common;
    cur_realtime_next = cur_realtime;
    cur_mode_next     = cur_mode;
    sysex_length_next = sysex_length;
    emit              = 1'b0;
    ev                = '0;
    wr                = '0;
    mode_diff         = 7'd0;

    // any status byte outside sysex restarts parsing
    if (is_status && phase != mbsp_pkg::PH_SYSEX) begin
      phase_next = mbsp_pkg::PH_EMPTY;
    end

    case (phase_next)
      mbsp_pkg::PH_EMPTY: begin
        if (is_status) begin
          cur_channel_next = in_byte[3:0];
          cur_type_next    = {1'b0, in_byte[6:4]};
          if (in_byte[7:3] == mbsp_pkg::RT_PREFIX) begin
            cur_type_next = mbsp_pkg::MT_REALTIME;
          end
          phase_next = mbsp_pkg::PH_STATUS;
          if (cur_type_next == mbsp_pkg::MT_SYSCOMMON) begin
            cur_channel_next = 4'd0;
            cur_common_next  = in_byte[2:0];
            if (cur_common_next == mbsp_pkg::SC_SYSEX) begin
              phase_next        = mbsp_pkg::PH_SYSEX;
              sysex_length_next = '0;
            end else if (cur_common_next > mbsp_pkg::SC_SONGSEL) begin
              phase_next = mbsp_pkg::PH_EMPTY;
              emit       = 1'b1;
            end
          end else if (cur_type_next == mbsp_pkg::MT_REALTIME) begin
            cur_realtime_next = in_byte[2:0];
            phase_next        = mbsp_pkg::PH_EMPTY;
            emit              = 1'b1;
          end else begin
            running_type_next = cur_type_next;
          end
        end else if (running_type != mbsp_pkg::MT_NONE) begin
          cur_type_next  = running_type;
          cur_first_next = in_byte[6:0];
          if (running_type == mbsp_pkg::MT_CHANPRESS || running_type == mbsp_pkg::MT_PROGRAM ||
              cur_common == mbsp_pkg::SC_QFRAME || cur_common == mbsp_pkg::SC_SONGSEL) begin
            phase_next = mbsp_pkg::PH_EMPTY;
            emit       = 1'b1;
          end else begin
            phase_next = mbsp_pkg::PH_FIRST;
          end
        end
      end
      mbsp_pkg::PH_STATUS: begin
        cur_first_next = in_byte[6:0];
        if (running_type == mbsp_pkg::MT_CHANPRESS || running_type == mbsp_pkg::MT_PROGRAM ||
            cur_common == mbsp_pkg::SC_QFRAME || cur_common == mbsp_pkg::SC_SONGSEL) begin
          phase_next = mbsp_pkg::PH_EMPTY;
          emit       = 1'b1;
        end else begin
          phase_next = mbsp_pkg::PH_FIRST;
        end
        // the event below keeps the type from before this conversion
        ev = '{msg_type: cur_type_next, channel: cur_channel_next,
               first_data: cur_first_next, second_data: cur_second_next,
               common_subtype: cur_common_next, realtime_subtype: cur_realtime_next,
               mode_subtype: cur_mode_next, sysex_count: '0};
        if (running_type == mbsp_pkg::MT_CC && cur_first_next > mbsp_pkg::CC_LAST) begin
          mode_diff         = cur_first_next - mbsp_pkg::MODE_BASE;
          cur_type_next     = mbsp_pkg::MT_CHANMODE;
          running_type_next = mbsp_pkg::MT_CHANMODE;
          cur_mode_next     = mode_diff[2:0];
        end
      end
      mbsp_pkg::PH_FIRST: begin
        cur_second_next = in_byte[6:0];
        if (running_type == mbsp_pkg::MT_NOTEON && cur_second_next == 7'd0) begin
          cur_type_next = mbsp_pkg::MT_NOTEOFF;
        end
        emit       = 1'b1;
        phase_next = mbsp_pkg::PH_EMPTY;
      end
      mbsp_pkg::PH_SYSEX: begin
        if (in_byte == mbsp_pkg::BYTE_EOX) begin
          phase_next = mbsp_pkg::PH_EMPTY;
          emit       = 1'b1;
        end else if (sysex_length < mbsp_pkg::LEN_W'(mbsp_pkg::SYSEX_DEPTH)) begin
          wr                = '{en: 1'b1, addr: sysex_length[mbsp_pkg::SX_AW-1:0],
                                data: in_byte};
          sysex_length_next = sysex_length + mbsp_pkg::LEN_W'(1);
        end
      end
      default: begin
        phase_next = mbsp_pkg::PH_EMPTY;
      end
    endcase

    if (phase_next != mbsp_pkg::PH_STATUS || phase != mbsp_pkg::PH_STATUS || is_status) begin
      // snapshot of the finished message for every case but a data byte in PH_STATUS
      if (!(phase == mbsp_pkg::PH_STATUS && !is_status)) begin
        ev = '{msg_type: cur_type_next, channel: cur_channel_next,
               first_data: cur_first_next, second_data: cur_second_next,
               common_subtype: cur_common_next, realtime_subtype: cur_realtime_next,
               mode_subtype: cur_mode_next,
               sysex_count: (phase == mbsp_pkg::PH_SYSEX) ? sysex_length : '0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= mbsp_pkg::PH_EMPTY;
      running_type <= mbsp_pkg::MT_NONE;
      cur_type     <= mbsp_pkg::MT_NONE;
      cur_channel  <= 4'd0;
      cur_first    <= 7'd0;
      cur_second   <= 7'd0;
      cur_common   <= 3'd0;
      cur_realtime <= 3'd0;
      cur_mode     <= 3'd0;
      sysex_length <= '0;
      sx_wait      <= 1'b0;
    end else begin
      if (accept) begin
        phase        <= phase_next;
        running_type <= running_type_next;
        cur_type     <= cur_type_next;
        cur_channel  <= cur_channel_next;
        cur_first    <= cur_first_next;
        cur_second   <= cur_second_next;
        cur_common   <= cur_common_next;
        cur_realtime <= cur_realtime_next;
        cur_mode     <= cur_mode_next;
        sysex_length <= sysex_length_next;
      end
      if (push && ev.sysex_count != '0) begin
        sx_wait <= 1'b1;
      end else if (sx_done) begin
        sx_wait <= 1'b0;
      end
    end
  end

endmodule

// ===== design/mbsp_queue.sv =====
`timescale 1ns / 1ps
// Two-entry event queue between the parser front and the output back end.
// Depends on mbsp_pkg for the event type.
module mbsp_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mbsp_pkg::event_t push_event,
  output logic             full,
  input  logic             pop,
  output mbsp_pkg::event_t pop_event,
  output logic             empty
);

  mbsp_pkg::event_t entries [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;

  assign full      = (fill == 2'd2);
  assign empty     = (fill == 2'd0);
  assign pop_event = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_event;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== design/mbsp_back.sv =====
`timescale 1ns / 1ps
// Back end: sysex store, event unpacking into result transfers, output register.
// Depends on mbsp_pkg; fed by mbsp_queue and the front's store write port.
module mbsp_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_empty,
  input  mbsp_pkg::event_t       q_event,
  output logic                   pop,
  input  mbsp_pkg::sx_wr_t       sx_wr,
  output logic                   sx_done,
  output logic                   out_valid,
  input  logic                   out_ready,
  output mbsp_pkg::event_t       out_event,
  output logic [7:0]             out_value,
  output logic                   out_last
);

  logic [7:0]                    mem [mbsp_pkg::SYSEX_DEPTH];
  logic [7:0]                    rd_data;
  mbsp_pkg::back_state_t         state, state_next;
  mbsp_pkg::event_t              cur_ev;
  logic [mbsp_pkg::SX_AW-1:0]    idx;
  logic                          can_load;
  logic                          is_last;
  logic                          load_single;
  logic                          load_byte;
  logic                          start_run;

  assign can_load = !out_valid || out_ready;
  assign is_last  = (mbsp_pkg::LEN_W'(idx) + mbsp_pkg::LEN_W'(1)) == cur_ev.sysex_count;

  always_ff @(posedge clk) begin
    if (sx_wr.en) begin
      mem[sx_wr.addr] <= sx_wr.data;
    end
    rd_data <= mem[idx];
  end

  always_comb begin
    state_next  = state;
    pop         = 1'b0;
    load_single = 1'b0;
    load_byte   = 1'b0;
    start_run   = 1'b0;
    sx_done     = 1'b0;
    case (state)
      mbsp_pkg::BK_IDLE: begin
        if (!q_empty) begin
          if (q_event.sysex_count != '0) begin
            pop        = 1'b1;
            start_run  = 1'b1;
            state_next = mbsp_pkg::BK_READ;
          end else if (can_load) begin
            pop         = 1'b1;
            load_single = 1'b1;
          end
        end
      end
      mbsp_pkg::BK_READ: begin
        state_next = mbsp_pkg::BK_LOAD;
      end
      mbsp_pkg::BK_LOAD: begin
        if (can_load) begin
          load_byte = 1'b1;
          if (is_last) begin
            sx_done    = 1'b1;
            state_next = mbsp_pkg::BK_IDLE;
          end else begin
            state_next = mbsp_pkg::BK_READ;
          end
        end
      end
      default: begin
        state_next = mbsp_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= mbsp_pkg::BK_IDLE;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      state <= state_next;
      if (start_run) begin
        idx <= '0;
      end else if (load_byte && !is_last) begin
        idx <= idx + mbsp_pkg::SX_AW'(1);
      end
      if (load_single || load_byte) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_run) begin
      cur_ev <= q_event;
    end
    if (load_single) begin
      out_event <= q_event;
      out_value <= 8'd0;
      out_last  <= 1'b1;
    end else if (load_byte) begin
      out_event <= cur_ev;
      out_value <= rd_data;
      out_last  <= is_last;
    end
  end

endmodule

// ===== design/midi_byte_stream_parser.sv =====
`timescale 1ns / 1ps
// Top level of the MIDI byte stream parser with running status.
// Depends on mbsp_pkg, mbsp_front, mbsp_queue and mbsp_back.
//
//   side    | group                        | content
//   --------+------------------------------+------------------------------------
//   input   | s_tvalid s_tready s_tdata    | one MIDI byte per transfer
//   output  | m_tvalid m_tready m_tdata    | decoded event, or one stored sysex
//           | m_tuser m_tlast              | byte per transfer, tlast ends a run
//
// A byte is taken when s_tready is high; the front holds its parse state in
// registers. Events pass a two-entry queue to an output register, so the input
// keeps moving while a result waits. A sysex end of n stored bytes gives n
// transfers (registered store read); input holds until the run has left the
// store. Reset (rst, synchronous) clears the parser, queue and output valid.
module midi_byte_stream_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] midi_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [3:0] channel, [10:4] first_data, [17:11] second_data,
                                 // [20:18] common_subtype, [23:21] realtime_subtype,
                                 // [26:24] mode_subtype, [32:27] sysex_count,
                                 // [40:33] sysex_value, [47:41] zero
  output logic [3:0]  m_tuser,   // [3:0] msg_type
  output logic        m_tlast
);

  logic             q_full;
  logic             q_empty;
  logic             push;
  logic             pop;
  logic             sx_done;
  mbsp_pkg::event_t push_event;
  mbsp_pkg::event_t pop_event;
  mbsp_pkg::event_t out_event;
  mbsp_pkg::sx_wr_t sx_wr;
  logic [7:0]       out_value;

  mbsp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_byte    (s_tdata),
    .q_full     (q_full),
    .push       (push),
    .push_event (push_event),
    .sx_wr      (sx_wr),
    .sx_done    (sx_done)
  );

  mbsp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_event (push_event),
    .full       (q_full),
    .pop        (pop),
    .pop_event  (pop_event),
    .empty      (q_empty)
  );

  mbsp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_event    (pop_event),
    .pop        (pop),
    .sx_wr      (sx_wr),
    .sx_done    (sx_done),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_event  (out_event),
    .out_value  (out_value),
    .out_last   (m_tlast)
  );

  assign m_tuser = out_event.msg_type;
  assign m_tdata = {7'd0, out_value, out_event.sysex_count, out_event.mode_subtype,
                    out_event.realtime_subtype, out_event.common_subtype,
                    out_event.second_data, out_event.first_data, out_event.channel};

endmodule
